### hw/rtl/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes, tables and microcode layout for the seven-segment
// display command encoder.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
    localparam logic [7:0] CTRL_RESET     = 8'h8A;
    localparam logic [3:0] ADDR_HIGH      = 4'hC;

    // request kinds
    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_GLYPH  = 3'd1;
    localparam logic [2:0] KIND_LED    = 3'd2;
    localparam logic [2:0] KIND_OFF    = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    // microprogram entry points
    localparam int          STEP_W       = 4;
    localparam logic [3:0]  STEP_HOME    = 4'd0;
    localparam logic [3:0]  STEP_CMD     = 4'd1;
    localparam logic [3:0]  STEP_CTRL    = 4'd2;
    localparam logic [3:0]  STEP_NUM     = 4'd3;
    localparam logic [3:0]  STEP_NUM_A   = 4'd4;
    localparam logic [3:0]  STEP_NUM_D   = 4'd5;
    localparam logic [3:0]  STEP_GLYPH   = 4'd6;
    localparam logic [3:0]  STEP_GLYPH_D = 4'd7;
    localparam logic [3:0]  STEP_LED     = 4'd8;
    localparam logic [3:0]  STEP_LED_D   = 4'd9;
    localparam logic [3:0]  STEP_OFF     = 4'd10;
    localparam logic [3:0]  STEP_OFF_D   = 4'd11;
    localparam logic [3:0]  STEP_CLR     = 4'd12;
    localparam logic [3:0]  STEP_CLR_D   = 4'd13;

    localparam logic [3:0]  LIMIT_DIGITS = 4'd7;
    localparam logic [3:0]  LIMIT_CLEAR  = 4'd15;

    typedef struct packed {
        logic [2:0]  kind;
        logic [26:0] value;
        logic [2:0]  position;
        logic [3:0]  glyph;
        logic        point;
        logic        led_on;
    } req_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       last;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_DISPATCH,
        OP_EMIT,
        OP_DIV
    } op_t;

    typedef enum logic [3:0] {
        SRC_CMD,
        SRC_CTRL,
        SRC_ADDR_DIGIT,
        SRC_SEG_DIGIT,
        SRC_ADDR_POS,
        SRC_ADDR_LED,
        SRC_SEG_GLYPH,
        SRC_LED,
        SRC_POINT,
        SRC_ADDR_CLR,
        SRC_ZERO
    } src_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_LOOP
    } last_t;

    typedef enum logic [1:0] {
        NX_SEQ,
        NX_KIND,
        NX_LOOP,
        NX_HOME
    } next_t;

    typedef struct packed {
        op_t         op;
        src_t        src;
        logic        frame_end;
        last_t       last_mode;
        next_t       next_mode;
        logic [3:0]  target;
        logic [3:0]  limit;
    } cw_t;

    // sequencer to datapath
    typedef struct packed {
        logic       load;
        logic       div_en;
        logic       loop_adv;
        src_t       src;
        logic [3:0] limit;
    } dp_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic [2:0] kind;
        logic       div_done;
        logic       loop_done;
    } dp_stat_t;

    // common-cathode segment codes, bit 0 = segment a
    function automatic logic [7:0] seg_code(input logic [3:0] g);
        logic [7:0] s;
        case (g)
            4'h0:    s = 8'h3F;
            4'h1:    s = 8'h06;
            4'h2:    s = 8'h5B;
            4'h3:    s = 8'h4F;
            4'h4:    s = 8'h66;
            4'h5:    s = 8'h6D;
            4'h6:    s = 8'h7D;
            4'h7:    s = 8'h07;
            4'h8:    s = 8'h7F;
            4'h9:    s = 8'h6F;
            4'hA:    s = 8'h77;
            4'hB:    s = 8'h7C;
            4'hC:    s = 8'h39;
            4'hD:    s = 8'h5E;
            4'hE:    s = 8'h79;
            default: s = 8'h71;
        endcase
        return s;
    endfunction

    // place weight of each digit, leftmost first
    function automatic logic [26:0] pow10(input logic [2:0] i);
        logic [26:0] p;
        case (i)
            3'd0:    p = 27'd10000000;
            3'd1:    p = 27'd1000000;
            3'd2:    p = 27'd100000;
            3'd3:    p = 27'd10000;
            3'd4:    p = 27'd1000;
            3'd5:    p = 27'd100;
            3'd6:    p = 27'd10;
            default: p = 27'd1;
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/ssd_ucode_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_ucode_rom
// Read-only microprogram: one control word per sequencer step.
// ----------------------------------------------------------------------------
module ssd_ucode_rom (
    input  logic [ssd_pkg::STEP_W-1:0] step,
    output ssd_pkg::cw_t               cw
);

    function automatic ssd_pkg::cw_t mk(
        input ssd_pkg::op_t   op,
        input ssd_pkg::src_t  src,
        input logic           fe,
        input ssd_pkg::last_t lm,
        input ssd_pkg::next_t nm,
        input logic [3:0]     tgt,
        input logic [3:0]     lim
    );
        ssd_pkg::cw_t w;
        w.op        = op;
        w.src       = src;
        w.frame_end = fe;
        w.last_mode = lm;
        w.next_mode = nm;
        w.target    = tgt;
        w.limit     = lim;
        return w;
    endfunction

    always_comb
    begin
        case (step)
            ssd_pkg::STEP_HOME:
                cw = mk(ssd_pkg::OP_DISPATCH, ssd_pkg::SRC_ZERO, 1'b0, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_SEQ, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_CMD:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_CMD, 1'b1, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_SEQ, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_CTRL:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_CTRL, 1'b1, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_KIND, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_NUM:
                cw = mk(ssd_pkg::OP_DIV, ssd_pkg::SRC_ZERO, 1'b0, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_SEQ, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_NUM_A:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_ADDR_DIGIT, 1'b0, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_SEQ, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_NUM_D:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_SEG_DIGIT, 1'b1, ssd_pkg::LAST_LOOP,
                        ssd_pkg::NX_LOOP, ssd_pkg::STEP_NUM, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_GLYPH:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_ADDR_POS, 1'b0, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_SEQ, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_GLYPH_D:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_SEG_GLYPH, 1'b1, ssd_pkg::LAST_YES,
                        ssd_pkg::NX_HOME, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_LED:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_ADDR_LED, 1'b0, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_SEQ, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_LED_D:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_LED, 1'b1, ssd_pkg::LAST_YES,
                        ssd_pkg::NX_HOME, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_OFF:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_ADDR_POS, 1'b0, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_SEQ, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_OFF_D:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_POINT, 1'b1, ssd_pkg::LAST_YES,
                        ssd_pkg::NX_HOME, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
            ssd_pkg::STEP_CLR:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_ADDR_CLR, 1'b0, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_SEQ, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_CLEAR);
            ssd_pkg::STEP_CLR_D:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_ZERO, 1'b1, ssd_pkg::LAST_LOOP,
                        ssd_pkg::NX_LOOP, ssd_pkg::STEP_CLR, ssd_pkg::LIMIT_CLEAR);
            default:
                cw = mk(ssd_pkg::OP_EMIT, ssd_pkg::SRC_ZERO, 1'b0, ssd_pkg::LAST_NO,
                        ssd_pkg::NX_HOME, ssd_pkg::STEP_HOME, ssd_pkg::LIMIT_DIGITS);
        endcase
    end

endmodule

### hw/rtl/ssd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_datapath
// Request holding registers, digit extraction by repeated subtraction,
// loop index and frame byte selection.
// ----------------------------------------------------------------------------
module ssd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ssd_pkg::dp_ctrl_t  ctrl,
    input  ssd_pkg::req_t      req,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    output ssd_pkg::dp_stat_t  stat,
    output logic [7:0]         frame_byte
);

    ssd_pkg::req_t req_reg;
    logic [26:0]   rem_reg,   rem_next;
    logic [3:0]    digit_reg, digit_next;
    logic [3:0]    idx_reg,   idx_next;
    logic [7:0]    ctrl_byte_reg;
    logic [26:0]   weight;
    logic          ge;

    assign weight = ssd_pkg::pow10(idx_reg[2:0]);
    assign ge     = (rem_reg >= weight);

    always_comb
    begin
        rem_next   = rem_reg;
        digit_next = digit_reg;
        idx_next   = idx_reg;
        if (ctrl.load)
        begin
            rem_next   = req.value;
            digit_next = 4'd0;
            idx_next   = 4'd0;
        end
        else if (ctrl.div_en && ge)
        begin
            rem_next   = rem_reg - weight;
            digit_next = digit_reg + 4'd1;
        end
        else if (ctrl.loop_adv)
        begin
            digit_next = 4'd0;
            idx_next   = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_byte_reg <= ssd_pkg::CTRL_RESET;
        else if (cfg_we)
            ctrl_byte_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            req_reg <= req;
        rem_reg   <= rem_next;
        digit_reg <= digit_next;
        idx_reg   <= idx_next;
    end

    assign stat.kind      = req_reg.kind;
    assign stat.div_done  = !ge;
    assign stat.loop_done = (idx_reg == ctrl.limit);

    always_comb
    begin
        case (ctrl.src)
            ssd_pkg::SRC_CMD:        frame_byte = ssd_pkg::CMD_DATA_FIXED;
            ssd_pkg::SRC_CTRL:       frame_byte = ctrl_byte_reg;
            ssd_pkg::SRC_ADDR_DIGIT: frame_byte = {ssd_pkg::ADDR_HIGH, idx_reg[2:0], 1'b0};
            ssd_pkg::SRC_SEG_DIGIT:  frame_byte = ssd_pkg::seg_code(digit_reg);
            ssd_pkg::SRC_ADDR_POS:   frame_byte = {ssd_pkg::ADDR_HIGH, req_reg.position, 1'b0};
            ssd_pkg::SRC_ADDR_LED:   frame_byte = {ssd_pkg::ADDR_HIGH, req_reg.position, 1'b1};
            ssd_pkg::SRC_SEG_GLYPH:  frame_byte = ssd_pkg::seg_code(req_reg.glyph)
                                                  | {req_reg.point, 7'b0};
            ssd_pkg::SRC_LED:        frame_byte = {7'b0, req_reg.led_on};
            ssd_pkg::SRC_POINT:      frame_byte = {req_reg.point, 7'b0};
            ssd_pkg::SRC_ADDR_CLR:   frame_byte = {ssd_pkg::ADDR_HIGH, idx_reg};
            default:                 frame_byte = 8'h00;
        endcase
    end

endmodule

### hw/rtl/seven_segment_display_command_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_display_command_encoder_core
// Microcoded encoder turning display requests into driver-chip frame bytes.
// ----------------------------------------------------------------------------
// Channels: req (valid/ready, one display request per transfer), rsp
// (valid/ready, one frame byte per transfer, last marks the request's final
// byte) and cfg (valid/ready, display control byte, always ready).
// The first byte (0x44) follows the request transfer through the step
// and output registers. A number's digits are found by repeated
// subtraction of the place weight, digit d taking d subtractions.
// An unused kind is taken and dropped. The next request is taken once
// the last byte sits in the output register. Request throughput is set
// by the single-step sequencer and its one subtractor.
// Reset returns the sequencer to its dispatch step, empties the output
// register and loads the display control byte with 0x8A.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits on its emit step, so nothing is lost.
// ----------------------------------------------------------------------------
module seven_segment_display_command_encoder_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ssd_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ssd_pkg::rsp_t  rsp_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_data
);

    logic [ssd_pkg::STEP_W-1:0] step_reg, step_next;
    ssd_pkg::cw_t               cw;
    ssd_pkg::dp_ctrl_t          dp_ctrl;
    ssd_pkg::dp_stat_t          dp_stat;
    logic [7:0]                 dp_byte;
    logic                       out_valid_reg, out_valid_next;
    ssd_pkg::rsp_t              out_reg;
    logic                       can_emit;
    logic                       emit_fire;
    logic                       kind_ok;
    logic                       last_bit;
    logic [ssd_pkg::STEP_W-1:0] kind_entry;

    ssd_ucode_rom u_rom (
        .step (step_reg),
        .cw   (cw)
    );

    // configuration is taken in any cycle
    assign cfg_ready = 1'b1;

    // output register frees when its byte transfers this cycle
    assign can_emit  = !out_valid_reg || rsp_ready;
    assign emit_fire = (cw.op == ssd_pkg::OP_EMIT) && can_emit;
    assign req_ready = (cw.op == ssd_pkg::OP_DISPATCH);
    assign kind_ok   = (req_data.kind <= ssd_pkg::KIND_CLEAR);

    assign dp_ctrl.load     = req_ready && req_valid;
    assign dp_ctrl.div_en   = (cw.op == ssd_pkg::OP_DIV);
    assign dp_ctrl.loop_adv = emit_fire && (cw.next_mode == ssd_pkg::NX_LOOP);
    assign dp_ctrl.src      = cw.src;
    assign dp_ctrl.limit    = cw.limit;

    ssd_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dp_ctrl),
        .req        (req_data),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .stat       (dp_stat),
        .frame_byte (dp_byte)
    );

    // entry step for each request kind
    always_comb
    begin
        case (dp_stat.kind)
            ssd_pkg::KIND_NUMBER: kind_entry = ssd_pkg::STEP_NUM;
            ssd_pkg::KIND_GLYPH:  kind_entry = ssd_pkg::STEP_GLYPH;
            ssd_pkg::KIND_LED:    kind_entry = ssd_pkg::STEP_LED;
            ssd_pkg::KIND_OFF:    kind_entry = ssd_pkg::STEP_OFF;
            ssd_pkg::KIND_CLEAR:  kind_entry = ssd_pkg::STEP_CLR;
            default:              kind_entry = ssd_pkg::STEP_HOME;
        endcase
    end

    // step counter: advance, branch or hold
    always_comb
    begin
        step_next = step_reg;
        case (cw.op)
            ssd_pkg::OP_DISPATCH:
            begin
                // an unused kind is taken and dropped here
                if (req_valid && kind_ok)
                    step_next = step_reg + 1'b1;
            end
            ssd_pkg::OP_DIV:
            begin
                if (dp_stat.div_done)
                    step_next = step_reg + 1'b1;
            end
            ssd_pkg::OP_EMIT:
            begin
                if (can_emit)
                begin
                    case (cw.next_mode)
                        ssd_pkg::NX_SEQ:  step_next = step_reg + 1'b1;
                        ssd_pkg::NX_KIND: step_next = kind_entry;
                        ssd_pkg::NX_LOOP: step_next = dp_stat.loop_done
                                                      ? ssd_pkg::STEP_HOME : cw.target;
                        default:          step_next = ssd_pkg::STEP_HOME;
                    endcase
                end
            end
            default: step_next = ssd_pkg::STEP_HOME;
        endcase
    end

    assign last_bit = (cw.last_mode == ssd_pkg::LAST_YES)
                   || ((cw.last_mode == ssd_pkg::LAST_LOOP) && dp_stat.loop_done);

    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ssd_pkg::STEP_HOME;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // load the output byte on each emit
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_reg.frame_byte <= dp_byte;
            out_reg.frame_end  <= cw.frame_end;
            out_reg.last       <= last_bit;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

### verif/ssd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_frame_checker
// Watches the request, response and control channels of the display command
// encoder, predicts the frame bytes of every accepted request and compares
// each response transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module ssd_frame_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  ssd_pkg::req_t  req_data,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  ssd_pkg::rsp_t  rsp_data,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [7:0]     cfg_data,
    output int             mismatch_count,
    output int             outstanding
);

    localparam logic [7:0] DIGIT_ADDR0  = 8'hC0;
    localparam logic [7:0] LED_ADDR0    = 8'hC1;
    localparam logic [7:0] POINT_MASK   = 8'h80;

    logic [7:0]    ctrl_copy;
    ssd_pkg::rsp_t expected_frames[$];
    ssd_pkg::rsp_t want;
    int            fails;

    function automatic logic [7:0] segments_for(input logic [3:0] g);
        logic [7:0] s;
        case (g)
            4'h0:    s = 8'h3F;
            4'h1:    s = 8'h06;
            4'h2:    s = 8'h5B;
            4'h3:    s = 8'h4F;
            4'h4:    s = 8'h66;
            4'h5:    s = 8'h6D;
            4'h6:    s = 8'h7D;
            4'h7:    s = 8'h07;
            4'h8:    s = 8'h7F;
            4'h9:    s = 8'h6F;
            4'hA:    s = 8'h77;
            4'hB:    s = 8'h7C;
            4'hC:    s = 8'h39;
            4'hD:    s = 8'h5E;
            4'hE:    s = 8'h79;
            default: s = 8'h71;
        endcase
        return s;
    endfunction

    function automatic ssd_pkg::rsp_t frame(input logic [7:0] b, input logic strobe);
        ssd_pkg::rsp_t f;
        f.frame_byte = b;
        f.frame_end  = strobe;
        f.last       = 1'b0;
        return f;
    endfunction

    // build the byte sequence of one request and queue it
    function automatic void encode_request(input ssd_pkg::req_t r);
        ssd_pkg::rsp_t seq [0:33];
        int            n;
        int            i;
        int            v;
        int            weight;
        int            d;
        logic [7:0]    pt;
        logic [7:0]    pos_offset;

        if (r.kind > ssd_pkg::KIND_CLEAR)
            return;
        pt         = r.point ? POINT_MASK : 8'h00;
        pos_offset = {4'b0, r.position, 1'b0};
        seq[0] = frame(ssd_pkg::CMD_DATA_FIXED, 1'b1);
        seq[1] = frame(ctrl_copy, 1'b1);
        n = 2;
        case (r.kind)
            ssd_pkg::KIND_NUMBER:
            begin
                v      = int'(r.value);
                weight = 10000000;
                for (i = 0; i < 8; i++)
                begin
                    // leftmost digit takes the whole quotient, up to 13
                    d = (i == 0) ? v / weight : (v / weight) % 10;
                    seq[n]     = frame(DIGIT_ADDR0 + 8'(2 * i), 1'b0);
                    seq[n + 1] = frame(segments_for(4'(d)), 1'b1);
                    n      = n + 2;
                    weight = weight / 10;
                end
            end
            ssd_pkg::KIND_GLYPH:
            begin
                seq[n]     = frame(DIGIT_ADDR0 + pos_offset, 1'b0);
                seq[n + 1] = frame(segments_for(r.glyph) | pt, 1'b1);
                n = n + 2;
            end
            ssd_pkg::KIND_LED:
            begin
                seq[n]     = frame(LED_ADDR0 + pos_offset, 1'b0);
                seq[n + 1] = frame({7'b0, r.led_on}, 1'b1);
                n = n + 2;
            end
            ssd_pkg::KIND_OFF:
            begin
                seq[n]     = frame(DIGIT_ADDR0 + pos_offset, 1'b0);
                seq[n + 1] = frame(pt, 1'b1);
                n = n + 2;
            end
            default:
            begin
                for (i = 0; i < 16; i++)
                begin
                    seq[n]     = frame(DIGIT_ADDR0 + 8'(i), 1'b0);
                    seq[n + 1] = frame(8'h00, 1'b1);
                    n = n + 2;
                end
            end
        endcase
        seq[n - 1].last = 1'b1;
        for (i = 0; i < n; i++)
            expected_frames.push_back(seq[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_copy = ssd_pkg::CTRL_RESET;
            expected_frames.delete();
            fails = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                ctrl_copy = cfg_data;
            if (rsp_valid && rsp_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected byte, expected none, got %02h end %b last %b",
                             $time, rsp_data.frame_byte, rsp_data.frame_end,
                             rsp_data.last);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (rsp_data.frame_byte !== want.frame_byte)
                    begin
                        fails++;
                        $display("%0t: frame_byte expected %02h, got %02h",
                                 $time, want.frame_byte, rsp_data.frame_byte);
                    end
                    if (rsp_data.frame_end !== want.frame_end)
                    begin
                        fails++;
                        $display("%0t: frame_end expected %b, got %b",
                                 $time, want.frame_end, rsp_data.frame_end);
                    end
                    if (rsp_data.last !== want.last)
                    begin
                        fails++;
                        $display("%0t: last expected %b, got %b",
                                 $time, want.last, rsp_data.last);
                    end
                end
            end
            if (req_valid && req_ready)
                encode_request(req_data);
            mismatch_count <= fails;
            outstanding    <= expected_frames.size();
        end
    end

endmodule

### verif/tb_seven_segment_display_command_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_display_command_encoder_core
// Drives display requests and control byte writes into the encoder, with
// random gaps on the request side and random stalls on the response side.
// A checker beside the block predicts and compares every frame byte; this
// top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_seven_segment_display_command_encoder_core;

    // kinds the block takes and drops without any bytes
    localparam logic [2:0]  KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0]  KIND_UNUSED_HI = 3'd7;
    localparam logic [7:0]  CTRL_LOWEST    = 8'h80;
    localparam logic [7:0]  CTRL_HIGHEST   = 8'h8F;
    localparam int          MAX_GAP        = 6;
    // the longest unstalled request is a number such as 129999999
    localparam int          SETTLE_CYCLES  = 120;
    localparam int          ITEMS_PER_PHASE = 120;
    localparam int unsigned CYCLE_LIMIT    = 1000000;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    ssd_pkg::req_t  req_data;
    logic           rsp_valid;
    logic           rsp_ready;
    ssd_pkg::rsp_t  rsp_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic  [7:0]    cfg_data;
    int             mismatch_count;
    int             outstanding;
    // when set, neither side idles: back-to-back transfers
    bit    calm = 1'b0;
    int unsigned cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    seven_segment_display_command_encoder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ssd_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_data       (rsp_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic ssd_pkg::req_t make_request(input logic [2:0] kind,
                                                   input int unsigned value,
                                                   input int pos, input int glyph,
                                                   input bit point, input bit led);
        ssd_pkg::req_t r;
        r.kind     = kind;
        r.value    = 27'(value);
        r.position = 3'(pos);
        r.glyph    = 4'(glyph);
        r.point    = point;
        r.led_on   = led;
        return r;
    endfunction

    // Mostly well-formed requests; a tenth are unused kinds. Numbers mix the
    // legal range, small values, the over-range band and the full field.
    function automatic ssd_pkg::req_t random_request();
        ssd_pkg::req_t r;
        int            pick;
        pick       = $urandom_range(0, 99);
        r.position = 3'($urandom_range(0, 7));
        r.glyph    = 4'($urandom_range(0, 15));
        r.point    = 1'($urandom_range(0, 1));
        r.led_on   = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       r.value = 27'($urandom_range(0, 999));
            1:       r.value = 27'($urandom_range(0, 99999999));
            2:       r.value = 27'($urandom_range(100000000, 134217727));
            default: r.value = 27'($urandom);
        endcase
        if (pick < 30)
            r.kind = ssd_pkg::KIND_NUMBER;
        else if (pick < 50)
            r.kind = ssd_pkg::KIND_GLYPH;
        else if (pick < 65)
            r.kind = ssd_pkg::KIND_LED;
        else if (pick < 80)
            r.kind = ssd_pkg::KIND_OFF;
        else if (pick < 90)
            r.kind = ssd_pkg::KIND_CLEAR;
        else
            r.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        return r;
    endfunction

    // Enter on a falling edge; leave on the falling edge after the transfer
    // with valid still high, so a back-to-back request never glitches it.
    task automatic send_request(input ssd_pkg::req_t r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_data  = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off until every predicted byte has gone, then let the block settle
    task automatic settle();
        req_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_ctrl(input logic [7:0] v);
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // count every request sent; re-draw idling every 40 requests
    task automatic run_random(input int count);
        int            accepted;
        ssd_pkg::req_t r;
        accepted = 0;
        while (accepted < count)
        begin
            if (accepted % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = random_request();
            send_request(r);
            accepted++;
        end
    endtask

    // response side: draw a stall before each byte
    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready = 1'b1;
            @(posedge clk);
            while (!(rsp_valid && rsp_ready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        req_valid = 1'b0;
        req_data  = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, still on the reset control byte
        send_request(make_request(ssd_pkg::KIND_NUMBER, 0, 0, 0, 1'b0, 1'b0));
        send_request(make_request(ssd_pkg::KIND_NUMBER, 99999999, 7, 15, 1'b1, 1'b1));
        send_request(make_request(ssd_pkg::KIND_NUMBER, 12345678, 0, 0, 1'b0, 1'b0));
        send_request(make_request(ssd_pkg::KIND_NUMBER, 90000001, 3, 9, 1'b1, 1'b0));
        // over-range numbers: the leftmost digit shows A to D
        send_request(make_request(ssd_pkg::KIND_NUMBER, 100000000, 0, 0, 1'b0, 1'b0));
        send_request(make_request(ssd_pkg::KIND_NUMBER, 130000009, 0, 0, 1'b0, 1'b0));
        send_request(make_request(ssd_pkg::KIND_NUMBER, 134217727, 7, 15, 1'b1, 1'b1));
        send_request(make_request(ssd_pkg::KIND_GLYPH, 0, 0, 0, 1'b0, 1'b0));
        send_request(make_request(ssd_pkg::KIND_GLYPH, 134217727, 7, 15, 1'b1, 1'b1));
        send_request(make_request(ssd_pkg::KIND_GLYPH, 5, 3, 10, 1'b1, 1'b0));
        send_request(make_request(ssd_pkg::KIND_LED, 0, 0, 0, 1'b0, 1'b1));
        send_request(make_request(ssd_pkg::KIND_LED, 134217727, 7, 15, 1'b1, 1'b0));
        send_request(make_request(ssd_pkg::KIND_LED, 0, 5, 4, 1'b0, 1'b1));
        // digit off, with and without the point
        send_request(make_request(ssd_pkg::KIND_OFF, 0, 0, 0, 1'b0, 1'b0));
        send_request(make_request(ssd_pkg::KIND_OFF, 134217727, 7, 15, 1'b1, 1'b1));
        send_request(make_request(ssd_pkg::KIND_CLEAR, 0, 0, 0, 1'b0, 1'b0));
        send_request(make_request(ssd_pkg::KIND_CLEAR, 134217727, 7, 15, 1'b1, 1'b1));
        // unused kinds: dropped, no bytes
        send_request(make_request(KIND_UNUSED_LO, 134217727, 7, 15, 1'b1, 1'b1));
        send_request(make_request(KIND_UNUSED_LO + 3'd1, 0, 0, 0, 1'b0, 1'b0));
        send_request(make_request(KIND_UNUSED_HI, 12345678, 2, 6, 1'b1, 1'b0));
        send_request(make_request(ssd_pkg::KIND_GLYPH, 0, 1, 8, 1'b0, 1'b0));

        // random phases, each on its own control byte written while idle
        settle();
        write_ctrl(CTRL_LOWEST);
        run_random(ITEMS_PER_PHASE);
        settle();
        write_ctrl(CTRL_HIGHEST);
        run_random(ITEMS_PER_PHASE);
        settle();
        write_ctrl(8'($urandom_range(CTRL_LOWEST, CTRL_HIGHEST)));
        run_random(ITEMS_PER_PHASE);
        settle();
        write_ctrl(ssd_pkg::CTRL_RESET);
        run_random(ITEMS_PER_PHASE);
        settle();

        if (mismatch_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
